// ===== src/wbps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package wbps_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_SCAN  = 2'd2
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] value;
    logic       flag;
  } item_t;

  localparam int unsigned CFG_WIDTH    = 8;
  localparam int unsigned RESULT_WIDTH = 32;
  localparam logic [CFG_WIDTH-1:0] LENGTH_RESET = 8'd1;

endpackage
`default_nettype wire

// ===== src/wbps_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wbps_front
  import wbps_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = 128,
  parameter int unsigned IDX_W       = 7
) (
  input  wire logic [1:0]       action,
  input  wire logic [6:0]       entry_index,
  input  wire logic [7:0]       entry_byte,
  input  wire logic             entry_wild,
  input  wire logic [7:0]       data_byte,
  input  wire logic             last_byte,
  input  wire logic             beat_valid,
  output item_t                 push_item,
  output logic [IDX_W-1:0]      push_idx,
  output logic                  push_valid
);

  localparam int unsigned INDEX_SPAN = 128;

  // Entry indices wrap modulo the pattern depth; the wrap is a constant table.
  function automatic logic [INDEX_SPAN*IDX_W-1:0] build_wrap();
    logic [INDEX_SPAN*IDX_W-1:0] tab;
    tab = '0;
    for (int i = 0; i < INDEX_SPAN; i++) begin
      tab[i*IDX_W +: IDX_W] = IDX_W'(i % PATTERN_MAX);
    end
    return tab;
  endfunction

  localparam logic [INDEX_SPAN*IDX_W-1:0] WRAP_TAB = build_wrap();

  op_t kind;

  assign kind     = op_t'(action);
  assign push_idx = WRAP_TAB[entry_index*IDX_W +: IDX_W];

  always_comb begin
    push_item.op    = kind;
    push_item.value = entry_byte;
    push_item.flag  = entry_wild;
    push_valid      = 1'b0;
    case (kind)
      OP_LOAD: begin
        push_valid = beat_valid;
      end
      OP_START: begin
        push_valid = beat_valid;
      end
      OP_SCAN: begin
        push_item.value = data_byte;
        push_item.flag  = last_byte;
        push_valid      = beat_valid;
      end
      default: begin
        push_valid = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/wbps_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wbps_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             s_valid,
  output logic                  s_ready,
  input  wire logic [WIDTH-1:0] s_data,
  output logic                  m_valid,
  input  wire logic             m_ready,
  output logic [WIDTH-1:0]      m_data
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign s_ready = (cnt_r != CW'(DEPTH));
  assign m_valid = (cnt_r != '0);
  assign m_data  = mem_r[rd_ptr_r];
  assign do_push = s_valid && s_ready;
  assign do_pop  = m_valid && m_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= s_data;
    end
  end

endmodule
`default_nettype wire

// ===== src/wbps_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wbps_back
  import wbps_pkg::*;
#(
  parameter int unsigned PATTERN_MAX  = 128,
  parameter int unsigned OFFSET_WIDTH = 32,
  parameter int unsigned IDX_W        = 7
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_WIDTH-1:0]    cfg_data,
  input  wire logic                    q_valid,
  output logic                         q_ready,
  input  wire item_t                   q_item,
  input  wire logic [IDX_W-1:0]        q_idx,
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic [RESULT_WIDTH-1:0]      out_tdata,
  output logic                         out_tuser,
  output logic                         out_tlast
);

  localparam int unsigned LW  = $clog2(PATTERN_MAX + 1);
  localparam int unsigned TN  = 2 * PATTERN_MAX - 1;
  localparam int unsigned TW  = $clog2(TN);
  localparam int unsigned CLW = (LW > CFG_WIDTH) ? LW : CFG_WIDTH;
  localparam int unsigned MW  = (OFFSET_WIDTH > LW) ? OFFSET_WIDTH : LW;

  // Cell c of the aligned table holds pattern position cur_len + PATTERN_MAX - 2 - c,
  // so cell PATTERN_MAX - 1 + k lines up with the window byte k places back.
  logic [7:0]               tab_byte_r [TN];
  logic                     tab_wild_r [TN];
  logic [7:0]               win_r [PATTERN_MAX];
  logic [7:0]               win_nxt [PATTERN_MAX];
  logic [CFG_WIDTH-1:0]     plen_r;
  logic [LW-1:0]            cur_len_r, cur_len_nxt;
  logic [OFFSET_WIDTH-1:0]  seen_r, seen_nxt, seen_inc;
  logic                     over_r, over_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_found_r, out_found_nxt;
  logic [RESULT_WIDTH-1:0]  out_offset_r, out_offset_nxt;

  logic [CLW-1:0]           plen_x;
  logic [LW-1:0]            tgt_len;
  logic                     adj_up, adj_dn, pop;
  logic                     do_load, do_start, do_scan;
  logic [TW-1:0]            ld_cell;
  logic [PATTERN_MAX-1:0]   hit;
  logic                     all_hit, found;
  logic [MW-1:0]            seen_x, len_x, diff_x;

  assign cfg_ready = 1'b1;

  always_comb begin
    plen_x = CLW'(plen_r);
    if (plen_x == '0) begin
      tgt_len = LW'(1);
    end else if (plen_x > CLW'(PATTERN_MAX)) begin
      tgt_len = LW'(PATTERN_MAX);
    end else begin
      tgt_len = LW'(plen_x);
    end
  end

  assign adj_up   = (cur_len_r < tgt_len);
  assign adj_dn   = (cur_len_r > tgt_len);
  assign q_ready  = !adj_up && !adj_dn && (!out_valid_r || out_tready);
  assign pop      = q_valid && q_ready;
  assign do_load  = pop && (q_item.op == OP_LOAD);
  assign do_start = pop && (q_item.op == OP_START);
  assign do_scan  = pop && (q_item.op == OP_SCAN) && !over_r;
  assign ld_cell  = TW'(cur_len_r) + TW'(PATTERN_MAX - 2) - TW'(q_idx);

  always_comb begin
    win_nxt[0] = q_item.value;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win_nxt[k] = win_r[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      hit[k] = (LW'(k) >= cur_len_r) || tab_wild_r[PATTERN_MAX-1+k] ||
               (tab_byte_r[PATTERN_MAX-1+k] == win_nxt[k]);
    end
    all_hit = &hit;
  end

  assign seen_inc = (seen_r == '1) ? seen_r : seen_r + 1'b1;
  assign seen_x   = MW'(seen_inc);
  assign len_x    = MW'(cur_len_r);
  assign diff_x   = seen_x - len_x;
  assign found    = (seen_x >= len_x) && all_hit;

  always_comb begin
    cur_len_nxt    = cur_len_r;
    seen_nxt       = seen_r;
    over_nxt       = over_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_found_nxt  = out_found_r;
    out_offset_nxt = out_offset_r;
    if (adj_up) begin
      cur_len_nxt = cur_len_r + 1'b1;
    end else if (adj_dn) begin
      cur_len_nxt = cur_len_r - 1'b1;
    end
    if (do_start) begin
      seen_nxt = '0;
      over_nxt = 1'b0;
    end
    if (do_scan) begin
      seen_nxt = seen_inc;
      if (found) begin
        over_nxt       = 1'b1;
        out_valid_nxt  = 1'b1;
        out_found_nxt  = 1'b1;
        out_offset_nxt = RESULT_WIDTH'(diff_x);
      end else if (q_item.flag) begin
        over_nxt       = 1'b1;
        out_valid_nxt  = 1'b1;
        out_found_nxt  = 1'b0;
        out_offset_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r      <= LENGTH_RESET;
      cur_len_r   <= LW'(1);
      seen_r      <= '0;
      over_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        plen_r <= cfg_data;
      end
      cur_len_r   <= cur_len_nxt;
      seen_r      <= seen_nxt;
      over_r      <= over_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r  <= out_found_nxt;
    out_offset_r <= out_offset_nxt;
    if (do_scan) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
  end

  // A length change slides the aligned table one cell per cycle.
  always_ff @(posedge clk) begin
    if (adj_up) begin
      for (int c = 1; c < TN; c++) begin
        tab_byte_r[c] <= tab_byte_r[c-1];
        tab_wild_r[c] <= tab_wild_r[c-1];
      end
    end else if (adj_dn) begin
      for (int c = 0; c < TN - 1; c++) begin
        tab_byte_r[c] <= tab_byte_r[c+1];
        tab_wild_r[c] <= tab_wild_r[c+1];
      end
    end else if (do_load) begin
      tab_byte_r[ld_cell] <= q_item.value;
      tab_wild_r[ld_cell] <= q_item.flag;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_offset_r;
  assign out_tuser  = out_found_r;
  assign out_tlast  = 1'b1;

endmodule
`default_nettype wire

// ===== src/wildcard_byte_pattern_search.sv =====
// The two-entry queue decouples the sides. A scan beat's result is registered in the queue and
// then in the output register before it is on the out_ channel. Throughput: one input beat
// per cycle while out_tready is high and no realignment runs. A pattern length write realigns
// the pattern table one position per cycle, and the next item waits until the realignment is done.
// Reset (synchronous, rst_n low) sets the length to 1 and clears the search state;
// pattern entries hold no defined value until they are loaded.
`timescale 1ns / 1ps
`default_nettype none
module wildcard_byte_pattern_search
  import wbps_pkg::*;
#(
  parameter int unsigned PATTERN_MAX  = 128,
  parameter int unsigned OFFSET_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_WIDTH-1:0] cfg_data,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // entry_index[6:0], entry_byte[14:7], entry_wild[15], data_byte[23:16]
  input  wire logic [23:0]          in_tdata,
  // action[1:0]
  input  wire logic [1:0]           in_tuser,
  input  wire logic                 in_tlast,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // match_offset[31:0]
  output logic [RESULT_WIDTH-1:0]   out_tdata,
  // found[0]
  output logic                      out_tuser,
  output logic                      out_tlast
);

  localparam int unsigned IDX_W = $clog2(PATTERN_MAX);
  localparam int unsigned QW    = $bits(item_t) + IDX_W;

  item_t             push_item, pop_item;
  logic [IDX_W-1:0]  push_idx, pop_idx;
  logic              push_valid, q_s_ready, q_m_valid, q_m_ready;
  logic [QW-1:0]     q_in, q_out;

  wbps_front #(
    .PATTERN_MAX (PATTERN_MAX),
    .IDX_W       (IDX_W)
  ) u_front (
    .action      (in_tuser),
    .entry_index (in_tdata[6:0]),
    .entry_byte  (in_tdata[14:7]),
    .entry_wild  (in_tdata[15]),
    .data_byte   (in_tdata[23:16]),
    .last_byte   (in_tlast),
    .beat_valid  (in_tvalid),
    .push_item   (push_item),
    .push_idx    (push_idx),
    .push_valid  (push_valid)
  );

  assign in_tready = q_s_ready;
  assign q_in      = {push_idx, push_item};
  assign pop_item  = item_t'(q_out[$bits(item_t)-1:0]);
  assign pop_idx   = q_out[QW-1:$bits(item_t)];

  wbps_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (push_valid),
    .s_ready (q_s_ready),
    .s_data  (q_in),
    .m_valid (q_m_valid),
    .m_ready (q_m_ready),
    .m_data  (q_out)
  );

  wbps_back #(
    .PATTERN_MAX  (PATTERN_MAX),
    .OFFSET_WIDTH (OFFSET_WIDTH),
    .IDX_W        (IDX_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .q_valid    (q_m_valid),
    .q_ready    (q_m_ready),
    .q_item     (pop_item),
    .q_idx      (pop_idx),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ===== test/wildcard_byte_pattern_search_checker.sv =====
`timescale 1ns / 1ps
module wildcard_byte_pattern_search_checker
  import wbps_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  input  wire logic                   cfg_ready,
  input  wire logic [CFG_WIDTH-1:0]   cfg_data,
  input  wire logic                   in_tvalid,
  input  wire logic                   in_tready,
  // entry_index[6:0], entry_byte[14:7], entry_wild[15], data_byte[23:16]
  input  wire logic [23:0]            in_tdata,
  // action[1:0]
  input  wire logic [1:0]             in_tuser,
  input  wire logic                   in_tlast,
  input  wire logic                   out_tvalid,
  input  wire logic                   out_tready,
  // match_offset[31:0]
  input  wire logic [RESULT_WIDTH-1:0] out_tdata,
  // found[0]
  input  wire logic                   out_tuser,
  input  wire logic                   out_tlast,
  output int                          failures,
  output int                          pending,
  output int                          results_checked,
  output int                          matches_seen
);

  localparam int SIG_DEPTH = 128;

  typedef struct {
    logic        found;
    logic [31:0] offset;
  } search_outcome_t;

  logic [7:0]           sig_byte [SIG_DEPTH];
  logic                 sig_wild [SIG_DEPTH];
  logic [7:0]           recent [SIG_DEPTH];
  logic [31:0]          scanned;
  logic                 finished;
  logic [CFG_WIDTH-1:0] sig_len;
  search_outcome_t      awaited_outcomes[$];
  search_outcome_t      oldest;

  function automatic int span_len();
    if (sig_len == 0) return 1;
    if (sig_len > SIG_DEPTH) return SIG_DEPTH;
    return int'(sig_len);
  endfunction

  task automatic report(input string msg);
    $display("%0t ns checker: %s", $time, msg);
    failures++;
  endtask

  // The newest byte sits at index 0; pattern position 0 lines up with the oldest
  // byte of the window.
  task automatic shift_and_compare(input logic [7:0] b, input logic last);
    int n;
    bit hit;
    search_outcome_t v;
    if (!finished) begin
      for (int k = SIG_DEPTH - 1; k > 0; k--) recent[k] = recent[k-1];
      recent[0] = b;
      if (scanned != 32'hFFFF_FFFF) scanned++;
      n = span_len();
      hit = (scanned >= n);
      for (int j = 0; j < n; j++) begin
        if (!sig_wild[j] && sig_byte[j] != recent[n-1-j]) hit = 0;
      end
      if (hit) begin
        v.found = 1'b1;
        v.offset = scanned - n;
        awaited_outcomes.push_back(v);
        finished = 1'b1;
      end else if (last) begin
        v.found = 1'b0;
        v.offset = '0;
        awaited_outcomes.push_back(v);
        finished = 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SIG_DEPTH; k++) recent[k] = '0;
      scanned = '0;
      finished = 1'b0;
      sig_len = LENGTH_RESET;
      awaited_outcomes.delete();
      failures = 0;
      results_checked = 0;
      matches_seen = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_outcomes.size() == 0) begin
          report($sformatf("unexpected result beat, found %0b offset %0d",
                           out_tuser, out_tdata));
        end else begin
          oldest = awaited_outcomes.pop_front();
          results_checked++;
          if (oldest.found) matches_seen++;
          if (out_tuser !== oldest.found)
            report($sformatf("found %0b, expected %0b", out_tuser, oldest.found));
          if (out_tdata !== oldest.offset)
            report($sformatf("match_offset %0d, expected %0d", out_tdata, oldest.offset));
          if (out_tlast !== 1'b1)
            report($sformatf("done flag %0b, expected 1", out_tlast));
        end
      end
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          OP_LOAD: begin
            sig_byte[in_tdata[6:0]] = in_tdata[14:7];
            sig_wild[in_tdata[6:0]] = in_tdata[15];
          end
          OP_START: begin
            for (int k = 0; k < SIG_DEPTH; k++) recent[k] = '0;
            scanned = '0;
            finished = 1'b0;
          end
          OP_SCAN: shift_and_compare(in_tdata[23:16], in_tlast);
          default: ;
        endcase
      end
      if (cfg_valid && cfg_ready) sig_len = cfg_data;
    end
    pending <= awaited_outcomes.size();
  end

endmodule

// ===== test/wildcard_byte_pattern_search_test.sv =====
`timescale 1ns / 1ps
module wildcard_byte_pattern_search_test;
  import wbps_pkg::*;

  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int         LIMIT       = 400000;
  localparam int         DRAIN_LIMIT = 4000;
  localparam int         SETTLE      = 10;
  localparam int         LONG_HOLD   = 300;
  localparam int         PHASE_ITEMS = 45;
  localparam int         SIG_DEPTH   = 128;
  localparam logic [7:0] PHASE_LENGTHS [12] = '{8'd2, 8'd128, 8'd3, 8'd0, 8'd5, 8'd255,
                                                 8'd8, 8'd16, 8'd4, 8'd64, 8'd7, 8'd1};

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic [CFG_WIDTH-1:0]    cfg_data = '0;
  logic                    in_tvalid = 1'b0;
  logic [23:0]             in_tdata = '0;
  logic [1:0]              in_tuser = '0;
  logic                    in_tlast = 1'b0;
  logic                    out_tready = 1'b0;
  logic                    cfg_ready;
  logic                    in_tready;
  logic                    out_tvalid;
  logic [RESULT_WIDTH-1:0] out_tdata;
  logic                    out_tuser;
  logic                    out_tlast;

  int failures;
  int pending;
  int results_checked;
  int matches_seen;

  bit         gaps_on = 1'b1;
  int         hold_asked = 0;
  int         hold_served = 0;
  int         beats = 0;
  int         lengths_used = 0;
  int         cur_len = 1;
  logic [7:0] shadow_byte [SIG_DEPTH];
  bit         shadow_wild [SIG_DEPTH];

  always #2 clk = ~clk;

  wildcard_byte_pattern_search uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  wildcard_byte_pattern_search_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .failures        (failures),
    .pending         (pending),
    .results_checked (results_checked),
    .matches_seen    (matches_seen)
  );

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("wildcard_byte_pattern_search_test: FAIL");
    $finish;
  end

  initial begin
    forever begin
      if (hold_asked != hold_served) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_served++;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  function automatic logic [23:0] pack_fields(input logic [6:0] idx, input logic [7:0] pat,
                                              input logic wild, input logic [7:0] data);
    return {data, wild, pat, idx};
  endfunction

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
    return shadow_byte[$urandom_range(0, cur_len - 1)];
  endfunction

  task automatic offer(input logic [1:0] act, input logic [23:0] fields, input logic last);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= fields;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic load_entry(input logic [6:0] idx, input logic [7:0] pat, input logic wild);
    shadow_byte[idx] = pat;
    shadow_wild[idx] = wild;
    offer(OP_LOAD, pack_fields(idx, pat, wild, 8'($urandom_range(0, 255))),
          1'($urandom_range(0, 1)));
    beats++;
  endtask

  task automatic start_search();
    offer(OP_START, 24'($urandom()), 1'($urandom_range(0, 1)));
    beats++;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic last);
    offer(OP_SCAN, pack_fields(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)), b), last);
    beats++;
  endtask

  task automatic stray_item();
    if ($urandom_range(0, 1) == 0)
      offer(ACT_UNUSED, 24'($urandom()), 1'($urandom_range(0, 1)));
    else
      load_entry(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 4) == 0));
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_length(input logic [7:0] len);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_len = (len == 0) ? 1 : (len > SIG_DEPTH) ? SIG_DEPTH : int'(len);
    lengths_used++;
  endtask

  // A region is random lead-in bytes, optionally a copy of the pattern with random
  // bytes in its wildcard positions, then random trailing bytes.
  task automatic run_search(input bit plant, input bit terminate);
    logic [7:0] region[$];
    int n;
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 4))
        load_entry(7'($urandom_range(0, cur_len - 1)), pick_byte(),
                   1'($urandom_range(0, 4) == 0));
    end
    start_search();
    repeat ($urandom_range(0, cur_len > 16 ? 6 : 10)) region.push_back(pick_byte());
    if (plant) begin
      for (int j = 0; j < cur_len; j++)
        region.push_back(shadow_wild[j] ? 8'($urandom_range(0, 255)) : shadow_byte[j]);
    end
    repeat ($urandom_range(plant ? 0 : 1, 4)) region.push_back(pick_byte());
    n = region.size();
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 24) == 0) stray_item();
      scan_byte(region[k], terminate && k == n - 1);
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) scan_byte(pick_byte(), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int phase_start;
    int waited;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < SIG_DEPTH; i++)
      load_entry(7'(i), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 4) == 0));

    // The length is still at its reset value of one here.
    load_entry(7'd0, 8'hFF, 1'b0);
    scan_byte(8'h00, 1'b0);
    scan_byte(8'hFF, 1'b0);
    scan_byte(8'hFF, 1'b1);
    offer(ACT_UNUSED, 24'hFF_FFFF, 1'b1);
    offer(OP_START, 24'h00_0000, 1'b0);
    beats++;
    scan_byte(8'h12, 1'b1);
    load_entry(7'd0, 8'h00, 1'b1);
    start_search();
    scan_byte(8'hAB, 1'b1);
    load_entry(7'd127, 8'hFF, 1'b0);
    load_entry(7'd0, 8'h00, 1'b0);
    start_search();
    scan_byte(8'hFF, 1'b0);
    scan_byte(8'h00, 1'b1);

    // Every single-byte region reports, so a long output stall backs up the input.
    hold_asked++;
    repeat (40) begin
      start_search();
      scan_byte(pick_byte(), 1'b1);
    end

    foreach (PHASE_LENGTHS[p]) begin
      if (p >= 9) gaps_on = 1'b0;
      set_length(PHASE_LENGTHS[p]);
      phase_start = beats;
      do begin
        run_search($urandom_range(0, 9) < 6, $urandom_range(0, 7) != 0);
      end while (beats - phase_start < PHASE_ITEMS);
    end

    in_tvalid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE) @(posedge clk);

    $display("Drove %0d input beats over %0d pattern length settings, with a %0d-cycle",
             beats, lengths_used, LONG_HOLD);
    $display("output stall; %0d result beats compared, %0d of them matches.",
             results_checked, matches_seen);
    if (failures == 0 && pending == 0) begin
      $display("wildcard_byte_pattern_search_test: PASS");
    end else begin
      $display("wildcard_byte_pattern_search_test: FAIL");
    end
    $finish;
  end

endmodule
